/* hdl/mwf_pkg.sv */
// shared types and constants for the morphology window filter
// no dependencies
package mwf_pkg;

  localparam int MaxWidth   = 1024;
  localparam int ColW       = 10;
  localparam int HalfWin    = 3;
  localparam int WinSize    = 7;
  localparam int StoreRows  = 6;
  localparam int DelayDepth = HalfWin * MaxWidth + 4;
  localparam int DelayAw    = 12;
  localparam int QueueDepth = 4;

  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_THRESH = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    MODE_ERODE    = 3'd0,
    MODE_DILATE   = 3'd1,
    MODE_GERODE   = 3'd2,
    MODE_GDILATE  = 3'd3,
    MODE_GRADIENT = 3'd4,
    MODE_TOPHAT   = 3'd5,
    MODE_BLACKHAT = 3'd6,
    MODE_THRESH   = 3'd7
  } mode_t;

  // classified work for the back part
  typedef struct packed {
    logic [ColW-1:0] col;
    logic [7:0]      src;
    logic [7:0]      org;
    logic            emit;
    logic [ColW-1:0] ocol;
    logic [11:0]     orow;
    logic            b7;
    logic            b1;
    logic            last;
  } work_t;

  function automatic logic disk_at(input int k, input int j);
    logic [6:0] row;
    case (k)
      0, 6:    row = 7'b0011100;
      1, 5:    row = 7'b0111110;
      default: row = 7'b1111111;
    endcase
    return row[j];
  endfunction

endpackage

/* hdl/mwf_front.sv */
// front part: position tracking, border classification
// depends on mwf_pkg
module mwf_front import mwf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  source_pixel,
  input  logic [7:0]  original_pixel,
  input  logic        start_of_frame,
  input  logic [10:0] frame_width,
  input  logic [12:0] frame_height,
  output logic        wr_valid,
  output work_t       wr_data,
  input  logic        q_full
);

  logic [10:0] in_column, in_column_next;
  logic [12:0] in_row, in_row_next;
  logic [10:0] w;
  logic [12:0] h;
  logic [10:0] c0;
  logic [12:0] r0;
  logic        dead, flush, started;
  logic [10:0] c1;
  logic [12:0] r1;
  logic [10:0] oc;
  logic [12:0] orw;

  assign in_ready = !q_full;

  always_comb begin
    w = frame_width;
    if (w < 11'd8) w = 11'd8;
    if (w > 11'(MaxWidth)) w = 11'(MaxWidth);
    h = frame_height;
    if (h < 13'd8) h = 13'd8;
    if (h > 13'd4096) h = 13'd4096;
    c0 = in_column;
    r0 = in_row;
    if (!command && start_of_frame) begin
      c0 = '0;
      r0 = '0;
    end
    if (c0 >= w) begin
      c0 = '0;
      r0 = r0 + 13'd1;
    end
    dead = ({1'b0, r0} > {1'b0, h} + 14'd3) ||
           ({1'b0, r0} == {1'b0, h} + 14'd3 && c0 >= 11'd3);
    flush = command || (r0 >= h);
    started = (r0 > 13'd3) || (r0 == 13'd3 && c0 >= 11'd3);
    c1 = c0 + 11'd1;
    r1 = r0;
    if (c1 >= w) begin
      c1 = '0;
      r1 = r0 + 13'd1;
    end
    if (c0 >= 11'd3) begin
      oc  = c0 - 11'd3;
      orw = r0 - 13'd3;
    end else begin
      oc  = c0 + w - 11'd3;
      orw = r0 - 13'd4;
    end
    in_column_next = dead ? c0 : c1;
    in_row_next    = dead ? r0 : r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
    end else if (in_valid && in_ready) begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
    end
  end

  assign wr_valid = in_valid && in_ready && !dead;

  always_comb begin
    wr_data.col  = c0[ColW-1:0];
    wr_data.src  = flush ? 8'd0 : source_pixel;
    wr_data.org  = flush ? 8'd0 : original_pixel;
    wr_data.emit = started;
    wr_data.ocol = oc[ColW-1:0];
    wr_data.orow = orw[11:0];
    wr_data.b7 = orw < 13'd3 || orw >= h - 13'd3 || oc < 11'd3 || oc >= w - 11'd3;
    wr_data.b1 = orw < 13'd1 || orw >= h - 13'd1 || oc < 11'd1 || oc >= w - 11'd1;
    wr_data.last = (orw == h - 13'd1) && (oc == w - 11'd1);
  end

endmodule

/* hdl/mwf_queue.sv */
// short fifo of classified words between front and back
// depends on mwf_pkg
module mwf_queue import mwf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  input  work_t wr_data,
  output logic  full,
  output logic  rd_valid,
  input  logic  rd_en,
  output work_t rd_data
);

  work_t       mem [QueueDepth];
  logic [1:0]  wp, rp;
  logic [2:0]  cnt;

  assign full     = cnt == 3'(QueueDepth);
  assign rd_valid = cnt != 3'd0;
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr_valid) wp <= wp + 2'd1;
      if (rd_en) rp <= rp + 2'd1;
      cnt <= cnt + 3'(wr_valid) - 3'(rd_en);
    end
  end

endmodule

/* hdl/mwf_back.sv */
// back part: line stores, window, delay store, mode compute, output reg
// depends on mwf_pkg
module mwf_back import mwf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_rd,
  input  work_t       q_data,
  input  logic [2:0]  mode,
  input  logic [10:0] frame_width,
  input  logic [8:0]  threshold_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  result_pixel,
  output logic [9:0]  out_column,
  output logic [11:0] out_row,
  output logic        frame_last
);

  logic [7:0] line_mem [StoreRows][MaxWidth];
  logic [7:0] dly_mem [DelayDepth];
  logic [7:0] win [WinSize][WinSize];
  logic [DelayAw-1:0] dwp, drp;
  logic [12:0] dsum;
  logic [10:0] w;

  // stage 1: read stores
  logic        s1_v;
  work_t       s1;
  logic [7:0]  s1_col [StoreRows];
  logic [7:0]  s1_org;
  // stage 2: window valid
  logic        s2_v;
  work_t       s2;
  logic [7:0]  s2_org;
  logic        adv1, adv2, stall, byp;

  function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a : b;
  endfunction

  assign stall = s2_v && s2.emit && out_valid && !out_ready;
  assign adv2  = !stall;
  assign q_rd  = q_valid && adv2;
  assign adv1  = adv2;
  assign byp   = s1_v && (s1.col == q_data.col);

  always_comb begin
    w = frame_width;
    if (w < 11'd8) w = 11'd8;
    if (w > 11'(MaxWidth)) w = 11'(MaxWidth);
    dsum = {1'b0, dwp} + 13'(DelayDepth) - (13'd3 * {2'b0, w} + 13'd3);
    if (dsum >= 13'(DelayDepth)) dsum = dsum - 13'(DelayDepth);
    drp = dsum[DelayAw-1:0];
  end

  // column read on pop, pushed-up column written back from stage 1;
  // a word right behind on the same column takes stage 1's column instead
  always_ff @(posedge clk) begin
    if (q_rd) begin
      for (int k = 0; k < StoreRows - 1; k++)
        s1_col[k] <= byp ? s1_col[k+1] : line_mem[k][q_data.col];
      s1_col[StoreRows-1] <= byp ? s1.src : line_mem[StoreRows-1][q_data.col];
      s1_org <= (drp == dwp) ? q_data.org : dly_mem[drp];
      s1     <= q_data;
      dly_mem[dwp] <= q_data.org;
    end
    if (adv1 && s1_v) begin
      for (int k = 0; k < StoreRows - 1; k++)
        line_mem[k][s1.col] <= s1_col[k+1];
      line_mem[StoreRows-1][s1.col] <= s1.src;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      dwp  <= '0;
    end else if (adv1) begin
      s1_v <= q_rd;
      if (q_rd) dwp <= (dwp == DelayAw'(DelayDepth - 1)) ? '0 : dwp + 1'b1;
    end
  end

  // window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
      for (int k = 0; k < WinSize; k++)
        for (int j = 0; j < WinSize; j++) win[k][j] <= '0;
    end else if (adv2) begin
      s2_v <= s1_v;
      if (s1_v) begin
        for (int k = 0; k < WinSize; k++) begin
          for (int j = 0; j < WinSize - 1; j++) win[k][j] <= win[k][j+1];
          win[k][WinSize-1] <= (k == WinSize - 1) ? s1.src : s1_col[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_v) begin
      s2     <= s1;
      s2_org <= s1_org;
    end
  end

  // compute from window: min and max trees over the disk with outside taps neutral, cross min and max, per-mode result
  logic       all_nz, any_full;
  logic [7:0] mn, mx, cmn, cmx, c, res;
  logic [7:0] lo [WinSize][WinSize];
  logic [7:0] hi [WinSize][WinSize];
  logic [7:0] rmn [WinSize];
  logic [7:0] rmx [WinSize];
  always_comb begin
    for (int k = 0; k < WinSize; k++) begin
      for (int j = 0; j < WinSize; j++) begin
        lo[k][j] = disk_at(k, j) ? win[k][j] : 8'hff;
        hi[k][j] = disk_at(k, j) ? win[k][j] : 8'h00;
      end
      rmn[k] = min2(min2(min2(lo[k][0], lo[k][1]), min2(lo[k][2], lo[k][3])),
                    min2(min2(lo[k][4], lo[k][5]), lo[k][6]));
      rmx[k] = max2(max2(max2(hi[k][0], hi[k][1]), max2(hi[k][2], hi[k][3])),
                    max2(max2(hi[k][4], hi[k][5]), hi[k][6]));
    end
    mn = min2(min2(min2(rmn[0], rmn[1]), min2(rmn[2], rmn[3])),
              min2(min2(rmn[4], rmn[5]), rmn[6]));
    mx = max2(max2(max2(rmx[0], rmx[1]), max2(rmx[2], rmx[3])),
              max2(max2(rmx[4], rmx[5]), rmx[6]));
    all_nz   = mn != 8'd0;
    any_full = mx == 8'hff;
    c = win[3][3];
    cmn = c;
    cmx = c;
    if (win[2][3] < cmn) cmn = win[2][3];
    if (win[4][3] < cmn) cmn = win[4][3];
    if (win[3][2] < cmn) cmn = win[3][2];
    if (win[3][4] < cmn) cmn = win[3][4];
    if (win[2][3] > cmx) cmx = win[2][3];
    if (win[4][3] > cmx) cmx = win[4][3];
    if (win[3][2] > cmx) cmx = win[3][2];
    if (win[3][4] > cmx) cmx = win[3][4];
    case (mode_t'(mode))
      MODE_ERODE:    res = s2.b7 ? 8'd0 : (all_nz ? 8'hff : 8'd0);
      MODE_DILATE:   res = s2.b7 ? 8'd0 : (any_full ? 8'hff : 8'd0);
      MODE_GERODE:   res = s2.b7 ? 8'd0 : mn;
      MODE_GDILATE:  res = s2.b7 ? 8'd0 : mx;
      MODE_GRADIENT: res = s2.b1 ? 8'd0 : cmx - cmn;
      MODE_TOPHAT:   res = s2_org - c;
      MODE_BLACKHAT: res = s2.b1 ? 8'd0 : c - s2_org;
      MODE_THRESH:   res = ({1'b0, s2_org} < threshold_level) ? 8'd0 : 8'hff;
      default:       res = 8'd0;
    endcase
  end

  // a waiting word is held until taken, whatever the pipeline does
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv2 && s2_v && s2.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s2_v && s2.emit) begin
      result_pixel <= res;
      out_column   <= s2.ocol;
      out_row      <= s2.orow;
      frame_last   <= s2.last;
    end
  end

endmodule

/* hdl/morphology_window_filter.sv */
// morphology window filter top: config regs, front, queue, back
// path: accepted word -> queue -> stage 1 -> stage 2 -> output register
// (result position lags the input stream by three rows plus three pixels)
// throughput: one word per cycle; output stalls hold the back part and the
// four-word queue absorbs them before the input is held
// reset: synchronous, clears position, window and registers to defaults
module morphology_window_filter import mwf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // source_pixel, original_pixel, start_of_frame
  input  logic        s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // result_pixel, out_column, out_row
  output logic        m_axis_tlast,  // frame_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  logic [2:0]  mode;
  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic [8:0]  threshold_level;
  logic        wr_valid, q_full, q_valid, q_rd;
  work_t       wr_data, q_data;
  logic [7:0]  result_pixel;
  logic [9:0]  out_column;
  logic [11:0] out_row;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= '0;
      frame_width     <= 11'd640;
      frame_height    <= 13'd480;
      threshold_level <= 9'd128;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_MODE:   mode            <= cfg_data[2:0];
        CFG_WIDTH:  frame_width     <= cfg_data[10:0];
        CFG_HEIGHT: frame_height    <= cfg_data;
        CFG_THRESH: threshold_level <= cfg_data[8:0];
        default:    mode            <= mode;
      endcase
    end
  end

  mwf_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .command(s_axis_tuser), .source_pixel(s_axis_tdata[7:0]),
    .original_pixel(s_axis_tdata[15:8]), .start_of_frame(s_axis_tdata[16]),
    .frame_width, .frame_height,
    .wr_valid, .wr_data, .q_full
  );

  mwf_queue u_queue (
    .clk, .rst, .wr_valid, .wr_data, .full(q_full),
    .rd_valid(q_valid), .rd_en(q_rd), .rd_data(q_data)
  );

  mwf_back u_back (
    .clk, .rst, .q_valid, .q_rd, .q_data,
    .mode, .frame_width, .threshold_level,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .result_pixel, .out_column, .out_row, .frame_last(m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_row, out_column, result_pixel};

endmodule
